// ----- sv/char_lcd_bus_sequencer_defines.svh -----
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// same-cycle implication, reset masked
`define CLBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define CLBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/clbs_pkg.sv -----
package clbs_pkg;

    localparam int ROM_DEPTH = 50;
    localparam int PC_W      = $clog2(ROM_DEPTH);

    localparam logic [PC_W-1:0] PC_XFER = PC_W'(0);
    localparam logic [PC_W-1:0] PC_INIT = PC_W'(7);
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(ROM_DEPTH - 1);

    localparam logic [15:0] WAIT_POWERUP_US = 16'd15000;
    localparam logic [15:0] WAIT_SECOND_US  = 16'd4100;
    localparam logic [15:0] WAIT_THIRD_US   = 16'd100;
    localparam logic [15:0] WAIT_CLEAR_US   = 16'd1640;
    localparam logic [15:0] WAIT_CMD_US     = 16'd40;

    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef enum logic [2:0] {
        CFG_FOUR_BIT_MODE,
        CFG_SETUP_CYCLES,
        CFG_ENABLE_HIGH_CYCLES,
        CFG_ENABLE_LOW_CYCLES,
        CFG_CYCLES_PER_US
    } cfg_reg_t;

    // data pin update applied before the segment is emitted
    typedef enum logic [2:0] {
        DL_KEEP,
        DL_FIRST,   // full byte, or high nibble in 4-bit mode
        DL_LOW,     // low nibble onto DB7..DB4
        DL_INIT,    // 0x3 on DB7..DB4
        DL_CLR4     // drop DB4 for the 4-bit switch
    } dl_op_t;

    typedef enum logic [2:0] {
        BSEL_ITEM,
        BSEL_FSET,
        BSEL_DOFF,
        BSEL_CLEAR,
        BSEL_ENTRY
    } bsel_t;

    typedef enum logic [2:0] {
        WSEL_ITEM,
        WSEL_POWERUP,
        WSEL_SECOND,
        WSEL_THIRD,
        WSEL_CMD,
        WSEL_CLEAR
    } wsel_t;

    typedef enum logic [1:0] {
        RR_KEEP,
        RR_ITEM,
        RR_ZERO
    } rr_op_t;

    typedef enum logic [1:0] {
        SEG_SETUP,
        SEG_HIGH,
        SEG_LOW,
        SEG_WAIT
    } seg_t;

    typedef struct packed {
        dl_op_t          dl;
        bsel_t           bsel;
        wsel_t           wsel;
        rr_op_t          rr;
        seg_t            seg;
        logic            fin;
        logic            jmp8;   // jump to target when in 8-bit mode
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t mk(input dl_op_t dl, input bsel_t bsel, input wsel_t wsel,
                                  input rr_op_t rr, input seg_t seg, input logic fin,
                                  input logic jmp8, input logic [PC_W-1:0] target);
        uword_t w;
        w.dl     = dl;
        w.bsel   = bsel;
        w.wsel   = wsel;
        w.rr     = rr;
        w.seg    = seg;
        w.fin    = fin;
        w.jmp8   = jmp8;
        w.target = target;
        return w;
    endfunction

    // one row of a seven-row byte transfer block placed at base
    function automatic uword_t xfer_row(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] base,
                                        input bsel_t bsel, input wsel_t wsel,
                                        input rr_op_t rr, input logic fin);
        logic [PC_W-1:0] diff;
        uword_t          w;
        diff = pc - base;
        case (diff[2:0])
            3'd0:    w = mk(DL_FIRST, bsel, wsel, rr, SEG_SETUP, 1'b0, 1'b0, base);
            3'd1:    w = mk(DL_KEEP, bsel, wsel, RR_KEEP, SEG_HIGH, 1'b0, 1'b0, base);
            3'd2:    w = mk(DL_KEEP, bsel, wsel, RR_KEEP, SEG_LOW, 1'b0, 1'b1,
                            base + PC_W'(6));
            3'd3:    w = mk(DL_LOW, bsel, wsel, RR_KEEP, SEG_SETUP, 1'b0, 1'b0, base);
            3'd4:    w = mk(DL_KEEP, bsel, wsel, RR_KEEP, SEG_HIGH, 1'b0, 1'b0, base);
            3'd5:    w = mk(DL_KEEP, bsel, wsel, RR_KEEP, SEG_LOW, 1'b0, 1'b0, base);
            default: w = mk(DL_KEEP, bsel, wsel, RR_KEEP, SEG_WAIT, fin, 1'b0, base);
        endcase
        return w;
    endfunction

    function automatic uword_t rom(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc) inside
            [0:6]:   w = xfer_row(pc, PC_W'(0), BSEL_ITEM, WSEL_ITEM, RR_ITEM, 1'b1);
            7:       w = mk(DL_KEEP, BSEL_ITEM, WSEL_POWERUP, RR_KEEP, SEG_WAIT,
                            1'b0, 1'b0, pc);
            8:       w = mk(DL_INIT, BSEL_ITEM, WSEL_ITEM, RR_ZERO, SEG_SETUP,
                            1'b0, 1'b0, pc);
            9, 13, 17, 20:
                     w = mk(DL_KEEP, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_HIGH,
                            1'b0, 1'b0, pc);
            10, 14, 21:
                     w = mk(DL_KEEP, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_LOW,
                            1'b0, 1'b0, pc);
            11:      w = mk(DL_KEEP, BSEL_ITEM, WSEL_SECOND, RR_KEEP, SEG_WAIT,
                            1'b0, 1'b0, pc);
            12, 16:  w = mk(DL_KEEP, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_SETUP,
                            1'b0, 1'b0, pc);
            15:      w = mk(DL_KEEP, BSEL_ITEM, WSEL_THIRD, RR_KEEP, SEG_WAIT,
                            1'b0, 1'b0, pc);
            18:      w = mk(DL_KEEP, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_LOW,
                            1'b0, 1'b1, PC_W'(22));
            19:      w = mk(DL_CLR4, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_SETUP,
                            1'b0, 1'b0, pc);
            [22:28]: w = xfer_row(pc, PC_W'(22), BSEL_FSET, WSEL_CMD, RR_ZERO, 1'b0);
            [29:35]: w = xfer_row(pc, PC_W'(29), BSEL_DOFF, WSEL_CMD, RR_ZERO, 1'b0);
            [36:42]: w = xfer_row(pc, PC_W'(36), BSEL_CLEAR, WSEL_CLEAR, RR_ZERO, 1'b0);
            [43:49]: w = xfer_row(pc, PC_W'(43), BSEL_ENTRY, WSEL_CMD, RR_ZERO, 1'b1);
            default: w = mk(DL_KEEP, BSEL_ITEM, WSEL_ITEM, RR_KEEP, SEG_WAIT,
                            1'b1, 1'b0, pc);
        endcase
        return w;
    endfunction

endpackage

// ----- sv/char_lcd_bus_sequencer.sv -----
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata: rs, rw, byte, wait_us, N, F, I/D, S; tuser: mode
// m_*      out  tvalid/tready    tdata: rs, rw, enable, DB7..DB0, hold; tlast: last segment
// cfg_*    in   cfg_wr_en        cfg_addr selects register, cfg_wdata is the value
//
// One segment per clock while the output is not stalled, from a 50-row microcode ROM,
// one row per segment; the item is taken while idle, and an 8-bit bus skips the 4-bit-only rows.
// An item is taken only when the sequencer is idle; it may be taken while the last
// segment of the previous item still sits in the output register.
// A stalled output freezes the step counter. Reset loads the register defaults and
// clears the rs, rw and data pin levels; no clearing pass.
`include "char_lcd_bus_sequencer_defines.svh"

module char_lcd_bus_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] reg_select, [1] read_write, [9:2] bus_byte, [25:10] wait_us, [26] two_lines,
    // [27] tall_font, [28] cursor_increment, [29] display_shift, [31:30] zero
    input  logic [31:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] rs_pin, [1] rw_pin, [2] enable_pin, [10:3] data_pins, [34:11] hold_cycles,
    // [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    clbs_pkg::seq_state_t           state_reg, state_next;
    logic [clbs_pkg::PC_W-1:0]      pc_reg, pc_next;

    logic       four_bit_reg;
    logic [7:0] setup_reg, en_high_reg, en_low_reg, cpu_reg;

    logic        rs_reg, rs_next, rw_reg, rw_next;
    logic [7:0]  data_reg, data_next;

    logic        item_rs_reg, item_rw_reg;
    logic [7:0]  item_byte_reg;
    logic [15:0] item_wait_reg;
    logic        item_n_reg, item_f_reg, item_id_reg, item_s_reg;

    logic        m_valid_reg, m_valid_next;
    logic        out_en_reg;
    logic [23:0] out_hold_reg, hold_next;
    logic        out_last_reg;

    clbs_pkg::uword_t w;
    logic        in_xfer, advance;
    logic [7:0]  byte_sel;
    logic [15:0] us_sel;

    assign s_tready = (state_reg == clbs_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign advance  = (state_reg == clbs_pkg::ST_RUN) && (!m_valid_reg || m_tready);
    assign w        = clbs_pkg::rom(pc_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_hold_reg, data_reg, out_en_reg, rw_reg, rs_reg};
    assign m_tlast  = out_last_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg <= 1'b0;
            setup_reg    <= 8'd2;
            en_high_reg  <= 8'd4;
            en_low_reg   <= 8'd4;
            cpu_reg      <= 8'd15;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                clbs_pkg::CFG_FOUR_BIT_MODE:      four_bit_reg <= cfg_wdata[0];
                clbs_pkg::CFG_SETUP_CYCLES:       setup_reg    <= cfg_wdata;
                clbs_pkg::CFG_ENABLE_HIGH_CYCLES: en_high_reg  <= cfg_wdata;
                clbs_pkg::CFG_ENABLE_LOW_CYCLES:  en_low_reg   <= cfg_wdata;
                clbs_pkg::CFG_CYCLES_PER_US:      cpu_reg      <= cfg_wdata;
                default:                          ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_rs_reg   <= s_tdata[0];
            item_rw_reg   <= s_tdata[1];
            item_byte_reg <= s_tdata[9:2];
            item_wait_reg <= s_tdata[25:10];
            item_n_reg    <= s_tdata[26];
            item_f_reg    <= s_tdata[27];
            item_id_reg   <= s_tdata[28];
            item_s_reg    <= s_tdata[29];
        end
    end

    // datapath operand selection
    always_comb
    begin
        case (w.bsel)
            clbs_pkg::BSEL_FSET:  byte_sel = {3'b001, !four_bit_reg, item_n_reg, item_f_reg, 2'b00};
            clbs_pkg::BSEL_DOFF:  byte_sel = clbs_pkg::CMD_DISPLAY_OFF;
            clbs_pkg::BSEL_CLEAR: byte_sel = clbs_pkg::CMD_CLEAR;
            clbs_pkg::BSEL_ENTRY: byte_sel = {6'b000001, item_id_reg, item_s_reg};
            default:              byte_sel = item_byte_reg;
        endcase

        case (w.wsel)
            clbs_pkg::WSEL_POWERUP: us_sel = clbs_pkg::WAIT_POWERUP_US;
            clbs_pkg::WSEL_SECOND:  us_sel = clbs_pkg::WAIT_SECOND_US;
            clbs_pkg::WSEL_THIRD:   us_sel = clbs_pkg::WAIT_THIRD_US;
            clbs_pkg::WSEL_CMD:     us_sel = clbs_pkg::WAIT_CMD_US;
            clbs_pkg::WSEL_CLEAR:   us_sel = clbs_pkg::WAIT_CLEAR_US;
            default:                us_sel = item_wait_reg;
        endcase

        case (w.seg)
            clbs_pkg::SEG_SETUP: hold_next = {16'd0, setup_reg};
            clbs_pkg::SEG_HIGH:  hold_next = {16'd0, en_high_reg};
            clbs_pkg::SEG_LOW:   hold_next = {16'd0, en_low_reg};
            default:             hold_next = {8'd0, us_sel} * {16'd0, cpu_reg};
        endcase
    end

    // sequencer: next step, pin levels and output register load
    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        rs_next      = rs_reg;
        rw_next      = rw_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            clbs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = clbs_pkg::ST_RUN;
                    pc_next    = s_tuser ? clbs_pkg::PC_INIT : clbs_pkg::PC_XFER;
                end
            end
            clbs_pkg::ST_RUN:
            begin
                if (advance)
                begin
                    case (w.rr)
                        clbs_pkg::RR_ITEM:
                        begin
                            rs_next = item_rs_reg;
                            rw_next = item_rw_reg;
                        end
                        clbs_pkg::RR_ZERO:
                        begin
                            rs_next = 1'b0;
                            rw_next = 1'b0;
                        end
                        default: ;
                    endcase

                    case (w.dl)
                        clbs_pkg::DL_FIRST:
                            data_next = four_bit_reg ? {byte_sel[7:4], data_reg[3:0]}
                                                     : byte_sel;
                        clbs_pkg::DL_LOW:
                            data_next = {byte_sel[3:0], data_reg[3:0]};
                        clbs_pkg::DL_INIT:
                            data_next = {4'h3, four_bit_reg ? data_reg[3:0] : 4'h0};
                        clbs_pkg::DL_CLR4:
                            data_next = data_reg & 8'hEF;
                        default: ;
                    endcase

                    m_valid_next = 1'b1;
                    if (w.fin)
                        state_next = clbs_pkg::ST_IDLE;
                    else if (w.jmp8 && !four_bit_reg)
                        pc_next = w.target;
                    else
                        pc_next = pc_reg + clbs_pkg::PC_W'(1);
                end
            end
            default: state_next = clbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= clbs_pkg::ST_IDLE;
            pc_reg      <= clbs_pkg::PC_XFER;
            rs_reg      <= 1'b0;
            rw_reg      <= 1'b0;
            data_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            rs_reg      <= rs_next;
            rw_reg      <= rw_next;
            data_reg    <= data_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_en_reg   <= (w.seg == clbs_pkg::SEG_HIGH);
            out_hold_reg <= hold_next;
            out_last_reg <= w.fin;
        end
    end

    `CLBS_ASSERT_NEXT(a_start_runs, in_xfer, state_reg == clbs_pkg::ST_RUN, "item taken, not running")
    `CLBS_ASSERT_NOW(a_pc_in_rom, state_reg == clbs_pkg::ST_RUN, pc_reg <= clbs_pkg::PC_LAST, "step past ROM")
    `CLBS_ASSERT_NOW(a_enable_not_last, m_valid_reg && out_en_reg, !out_last_reg, "enable high on last")
    `CLBS_ASSERT_NEXT(a_fin_idles, advance && w.fin, state_reg == clbs_pkg::ST_IDLE && m_valid_reg, "no idle after last")

endmodule
